// ===== hdl/acad_pkg.sv =====
`timescale 1ns / 1ps

package acad_pkg;

  localparam int ADDR_W      = 64;
  localparam int LEN_W       = 32;
  localparam int STRB_W      = 4;
  localparam int RESP_W      = 3;
  localparam int TIDX_W      = 2;
  localparam int COUNT_OUT_W = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // every access moves one 32-bit word
  localparam logic [LEN_W-1:0] MMIO_BYTES = 32'd4;
  localparam int               ALIGN_BITS = 2;

  localparam logic [ADDR_W-1:0] WIN_RESET_SIZE = 64'h0000_0000_0001_0000;

  typedef enum logic [1:0] {
    CMD_BUS    = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_DEBUG  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1
  } bus_op_e;

  typedef enum logic [RESP_W-1:0] {
    RESP_OK         = 3'd0,
    RESP_CMD_ERR    = 3'd1,
    RESP_BURST_ERR  = 3'd2,
    RESP_ADDR_ERR   = 3'd3,
    RESP_DEBUG_MISS = 3'd4
  } resp_e;

  // register index = {window, kind}
  typedef enum logic {
    CFG_BASE = 1'b0,
    CFG_SIZE = 1'b1
  } cfg_kind_e;

  typedef struct packed {
    logic [1:0]        command;
    logic              initiator;
    logic [1:0]        bus_op;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  access_length;
    logic [LEN_W-1:0]  streaming_width;
    logic              strobes_given;
    logic [STRB_W-1:0] strobes;
    logic              target_ok;
  } req_t;

  typedef struct packed {
    logic [RESP_W-1:0]      response;
    logic                   forward;
    logic [TIDX_W-1:0]      win_idx;
    logic [COUNT_OUT_W-1:0] request_count;
    logic [COUNT_OUT_W-1:0] forwarded_count;
    logic [COUNT_OUT_W-1:0] protocol_error_count;
    logic [COUNT_OUT_W-1:0] decode_error_count;
    logic [COUNT_OUT_W-1:0] target_error_count;
  } rsp_t;

  // registered item with its end address (address + length) precomputed
  typedef struct packed {
    req_t            req;
    logic [ADDR_W:0] addr_end;
  } item_t;

  // one window: first byte and one past the last byte
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W:0]   limit;
  } win_t;

  typedef struct packed {
    resp_e             response;
    logic              forward;
    logic [TIDX_W-1:0] win_idx;
    logic              initiator;
    logic              init_ok;
    logic              count_request;
    logic              count_forward;
    logic              count_protocol;
    logic              count_decode;
    logic              count_target;
    logic              clear;
  } dec_t;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0] request_count;
    logic [COUNT_OUT_W-1:0] forwarded_count;
    logic [COUNT_OUT_W-1:0] protocol_error_count;
    logic [COUNT_OUT_W-1:0] decode_error_count;
    logic [COUNT_OUT_W-1:0] target_error_count;
  } counts_t;

endpackage

// ===== hdl/acad_chan_if.sv =====
`timescale 1ns / 1ps

interface acad_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/acad_window_map.sv =====
`timescale 1ns / 1ps

module acad_window_map #(
  parameter int NUM_WINDOWS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [acad_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [acad_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output acad_pkg::win_t                      win_o [NUM_WINDOWS]
);

  for (genvar w = 0; w < NUM_WINDOWS; w++) begin : g_win
    localparam logic [acad_pkg::ADDR_W-1:0] RST_BASE =
      acad_pkg::ADDR_W'(w) * acad_pkg::WIN_RESET_SIZE;

    logic [acad_pkg::ADDR_W-1:0] base_q, base_d;
    logic [acad_pkg::ADDR_W-1:0] size_q, size_d;
    logic [acad_pkg::ADDR_W:0]   limit_q, limit_d;
    logic                        sel;

    assign sel = cfg_we_i && (cfg_idx_i[acad_pkg::CFG_IDX_W-1:1] == 2'(w));

    always_comb begin
      base_d  = base_q;
      size_d  = size_q;
      limit_d = limit_q;
      if (sel && cfg_idx_i[0] == acad_pkg::CFG_SIZE) begin
        size_d  = cfg_wdata_i;
        limit_d = {1'b0, base_q} + {1'b0, cfg_wdata_i};
      end else if (sel) begin
        base_d  = cfg_wdata_i;
        limit_d = {1'b0, cfg_wdata_i} + {1'b0, size_q};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        base_q  <= RST_BASE;
        size_q  <= acad_pkg::WIN_RESET_SIZE;
        limit_q <= {1'b0, RST_BASE} + {1'b0, acad_pkg::WIN_RESET_SIZE};
      end else begin
        base_q  <= base_d;
        size_q  <= size_d;
        limit_q <= limit_d;
      end
    end

    assign win_o[w].base  = base_q;
    assign win_o[w].limit = limit_q;
  end

endmodule

// ===== hdl/acad_decode.sv =====
`timescale 1ns / 1ps

module acad_decode #(
  parameter int NUM_WINDOWS    = 4,
  parameter int NUM_INITIATORS = 2
) (
  input  acad_pkg::item_t item_i,
  input  acad_pkg::win_t  win_i [NUM_WINDOWS],
  output acad_pkg::dec_t  dec_o
);

  logic [NUM_WINDOWS-1:0]          match;
  logic                            hit;
  logic [acad_pkg::TIDX_W-1:0]     hit_idx;
  logic                            op_bad;
  logic                            burst_bad;
  logic                            init_ok;
  logic [acad_pkg::ADDR_W:0]       addr_ext;
  acad_pkg::req_t                  req;

  assign req      = item_i.req;
  assign addr_ext = {1'b0, req.address};
  assign init_ok  = int'(req.initiator) < NUM_INITIATORS;

  // window holds the whole access; a zero length still needs its start inside
  always_comb begin
    for (int w = 0; w < NUM_WINDOWS; w++) begin
      match[w] = (req.address >= win_i[w].base)
              && (item_i.addr_end <= win_i[w].limit)
              && ((req.access_length != '0) || (addr_ext < win_i[w].limit));
    end
  end

  // lowest matching window wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int w = NUM_WINDOWS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit     = 1'b1;
        hit_idx = acad_pkg::TIDX_W'(w);
      end
    end
  end

  assign op_bad = (req.bus_op != acad_pkg::OP_READ) && (req.bus_op != acad_pkg::OP_WRITE);

  assign burst_bad = (req.access_length != acad_pkg::MMIO_BYTES)
                  || (req.address[acad_pkg::ALIGN_BITS-1:0] != '0)
                  || ((req.streaming_width != '0)
                      && (req.streaming_width < req.access_length))
                  || (req.strobes_given && (req.strobes != '1));

  always_comb begin
    dec_o                = '0;
    dec_o.response       = acad_pkg::RESP_OK;
    dec_o.initiator      = req.initiator;
    dec_o.init_ok        = init_ok;
    unique case (acad_pkg::cmd_e'(req.command))
      acad_pkg::CMD_BUS: begin
        dec_o.count_request = init_ok;
        if (op_bad) begin
          dec_o.response       = acad_pkg::RESP_CMD_ERR;
          dec_o.count_protocol = 1'b1;
        end else if (burst_bad) begin
          dec_o.response       = acad_pkg::RESP_BURST_ERR;
          dec_o.count_protocol = 1'b1;
        end else if (!hit) begin
          dec_o.response     = acad_pkg::RESP_ADDR_ERR;
          dec_o.count_decode = 1'b1;
        end else begin
          dec_o.forward       = 1'b1;
          dec_o.win_idx       = hit_idx;
          dec_o.count_forward = 1'b1;
        end
      end
      acad_pkg::CMD_REPORT: begin
        dec_o.count_target = !req.target_ok;
      end
      acad_pkg::CMD_DEBUG: begin
        if (hit) begin
          dec_o.forward = 1'b1;
          dec_o.win_idx = hit_idx;
        end else begin
          dec_o.response = acad_pkg::RESP_DEBUG_MISS;
        end
      end
      acad_pkg::CMD_CLEAR: begin
        dec_o.clear = 1'b1;
      end
    endcase
  end

endmodule

// ===== hdl/acad_counters.sv =====
`timescale 1ns / 1ps

module acad_counters #(
  parameter int NUM_WINDOWS    = 4,
  parameter int NUM_INITIATORS = 2,
  parameter int COUNTER_BITS   = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              upd_i,
  input  acad_pkg::dec_t    dec_i,
  output acad_pkg::counts_t counts_o
);

  typedef logic [COUNTER_BITS-1:0] cnt_t;

  cnt_t req_cnt_q [NUM_INITIATORS];
  cnt_t req_cnt_d [NUM_INITIATORS];
  cnt_t fwd_cnt_q [NUM_WINDOWS];
  cnt_t fwd_cnt_d [NUM_WINDOWS];
  cnt_t perr_q, perr_d;
  cnt_t derr_q, derr_d;
  cnt_t terr_q, terr_d;

  // saturating increment
  function automatic cnt_t bump(input cnt_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic logic [acad_pkg::COUNT_OUT_W-1:0] to_out(input cnt_t c);
    logic [63:0] wide;
    wide = 64'(c);
    return wide[acad_pkg::COUNT_OUT_W-1:0];
  endfunction

  always_comb begin
    for (int i = 0; i < NUM_INITIATORS; i++) begin
      if (dec_i.clear) begin
        req_cnt_d[i] = '0;
      end else if (dec_i.count_request && int'(dec_i.initiator) == i) begin
        req_cnt_d[i] = bump(req_cnt_q[i]);
      end else begin
        req_cnt_d[i] = req_cnt_q[i];
      end
    end
    for (int w = 0; w < NUM_WINDOWS; w++) begin
      if (dec_i.clear) begin
        fwd_cnt_d[w] = '0;
      end else if (dec_i.count_forward && dec_i.win_idx == acad_pkg::TIDX_W'(w)) begin
        fwd_cnt_d[w] = bump(fwd_cnt_q[w]);
      end else begin
        fwd_cnt_d[w] = fwd_cnt_q[w];
      end
    end
    perr_d = dec_i.clear ? '0 : (dec_i.count_protocol ? bump(perr_q) : perr_q);
    derr_d = dec_i.clear ? '0 : (dec_i.count_decode ? bump(derr_q) : derr_q);
    terr_d = dec_i.clear ? '0 : (dec_i.count_target ? bump(terr_q) : terr_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_cnt_q <= '{default: '0};
      fwd_cnt_q <= '{default: '0};
      perr_q    <= '0;
      derr_q    <= '0;
      terr_q    <= '0;
    end else if (upd_i) begin
      req_cnt_q <= req_cnt_d;
      fwd_cnt_q <= fwd_cnt_d;
      perr_q    <= perr_d;
      derr_q    <= derr_d;
      terr_q    <= terr_d;
    end
  end

  // values after this transaction's update
  always_comb begin
    counts_o = '0;
    for (int i = 0; i < NUM_INITIATORS; i++) begin
      if (dec_i.init_ok && int'(dec_i.initiator) == i) begin
        counts_o.request_count = to_out(req_cnt_d[i]);
      end
    end
    for (int w = 0; w < NUM_WINDOWS; w++) begin
      if (dec_i.forward && dec_i.win_idx == acad_pkg::TIDX_W'(w)) begin
        counts_o.forwarded_count = to_out(fwd_cnt_d[w]);
      end
    end
    counts_o.protocol_error_count = to_out(perr_d);
    counts_o.decode_error_count   = to_out(derr_d);
    counts_o.target_error_count   = to_out(terr_d);
  end

endmodule

// ===== hdl/axi4lite_control_address_decoder.sv =====
`timescale 1ns / 1ps

// channel   | dir | payload          | handshake
// ----------+-----+------------------+---------------------------------
// req_i     | in  | acad_pkg::req_t  | valid/ready, taken when both high
// rsp_o     | out | acad_pkg::rsp_t  | valid/ready, taken when both high
// cfg_*_i   | in  | window base/size | write on clk_i edge with cfg_we_i
//
// one transaction per clock sustained while rsp_o is not stalled; a taken
// request passes the request register, then decode and counter update into the
// response register
// a stalled response holds the response register; the request register still
// takes a new transaction, so two can be in flight before ready drops
// rst_ni is asynchronous: counters clear, windows return to their defaults

module axi4lite_control_address_decoder #(
  parameter int NUM_WINDOWS    = 4,
  parameter int NUM_INITIATORS = 2,
  parameter int COUNTER_BITS   = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [acad_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [acad_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  acad_chan_if.sink                       req_i,
  acad_chan_if.source                     rsp_o
);

  // request stage
  logic            item_valid_q, item_valid_d;
  acad_pkg::item_t item_q;
  logic            req_take;

  // response stage
  logic            rsp_valid_q, rsp_valid_d;
  acad_pkg::rsp_t  rsp_q, rsp_d;

  // request moves into the response register
  logic            adv;

  acad_pkg::win_t    win [NUM_WINDOWS];
  acad_pkg::dec_t    dec;
  acad_pkg::counts_t counts;

  assign adv          = item_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready  = !item_valid_q || adv;
  assign req_take     = req_i.valid && req_i.ready;

  assign item_valid_d = req_take ? 1'b1 : (adv ? 1'b0 : item_valid_q);
  assign rsp_valid_d  = adv ? 1'b1 : (rsp_o.ready ? 1'b0 : rsp_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  // payload registers, end address computed on the way in
  always_ff @(posedge clk_i) begin
    if (req_take) begin
      item_q.req      <= req_i.data;
      item_q.addr_end <= {1'b0, req_i.data.address}
                       + {{(acad_pkg::ADDR_W + 1 - acad_pkg::LEN_W){1'b0}},
                          req_i.data.access_length};
    end
    if (adv) begin
      rsp_q <= rsp_d;
    end
  end

  acad_window_map #(
    .NUM_WINDOWS (NUM_WINDOWS)
  ) u_window_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .win_o       (win)
  );

  // protocol checks and parallel window compares
  acad_decode #(
    .NUM_WINDOWS    (NUM_WINDOWS),
    .NUM_INITIATORS (NUM_INITIATORS)
  ) u_decode (
    .item_i (item_q),
    .win_i  (win),
    .dec_o  (dec)
  );

  // counters commit only when the transaction leaves the request register
  acad_counters #(
    .NUM_WINDOWS    (NUM_WINDOWS),
    .NUM_INITIATORS (NUM_INITIATORS),
    .COUNTER_BITS   (COUNTER_BITS)
  ) u_counters (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (adv),
    .dec_i    (dec),
    .counts_o (counts)
  );

  always_comb begin
    rsp_d.response             = dec.response;
    rsp_d.forward              = dec.forward;
    rsp_d.win_idx              = dec.win_idx;
    rsp_d.request_count        = counts.request_count;
    rsp_d.forwarded_count      = counts.forwarded_count;
    rsp_d.protocol_error_count = counts.protocol_error_count;
    rsp_d.decode_error_count   = counts.decode_error_count;
    rsp_d.target_error_count   = counts.target_error_count;
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // a routed transaction always reports success
  a_fwd_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_q.forward |-> rsp_q.response == acad_pkg::RESP_OK)
    else $error("forwarded transaction with error response");

  // no window, no window fields
  a_nofwd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp_q.forward |-> rsp_q.win_idx == '0
                                      && rsp_q.forwarded_count == '0)
    else $error("window fields set without forward");

  // clear leaves all totals at zero in its own response
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && dec.clear |=> rsp_q.protocol_error_count == '0
                        && rsp_q.decode_error_count == '0
                        && rsp_q.target_error_count == '0
                        && rsp_q.request_count == '0)
    else $error("clear did not zero counters");

  // a held request stays put until it can move on
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && !adv |=> item_valid_q && $stable(item_q))
    else $error("stalled request lost or changed");

endmodule
